// ----- rtl/gal_pkg.sv -----
// Shared types and constants for the Gaussian angle likelihood pipeline.
package gal_pkg;

  localparam int ANGLE_W = 20;
  localparam int CFG_W   = 11;
  localparam int PROB_W  = 32;
  localparam int ADDR_W  = 3;

  localparam logic [ADDR_W-1:0] ADDR_MIN_EXP_ARG = 3'd0;
  localparam logic signed [CFG_W-1:0] MIN_EXP_ARG_RST = -11'sd650;

  // expected angle codes below this are treated as zero
  localparam logic [ANGLE_W-1:0] TINY_EXP = 20'd2;

  localparam int QUOT_W    = 30;  // bits of d^2/(2r^2) in Q.20
  localparam int TAYLOR_N  = 13;
  localparam int PDIV_W    = 32;  // quotient bits of the final divide
  localparam int NUM_W     = 60;

  localparam logic [30:0] LOG2E_Q30    = 31'd1549082005;
  localparam logic [29:0] LN2_Q30      = 30'd744261118;
  localparam logic [28:0] INV_NORM_Q32 = 29'd272703090;
  localparam logic [63:0] EXP_BIAS     = 64'h2000_0000_0000_0000;
  localparam logic [11:0] KB_UNITY     = 12'd2074;
  localparam logic [11:0] KB_FAR       = 12'd60;
  localparam logic [30:0] TERM_ONE     = 31'h4000_0000;
  localparam logic [31:0] SUM_ONE      = 32'h4000_0000;
  localparam logic [PROB_W-1:0] OUT_MAX = '1;

  typedef struct packed {
    logic vld;
    logic zero;
    logic sat;
  } side_t;

  // ceil(2^34 / n): exact floor division by n for 30-bit values
  function automatic logic [34:0] recip(input int n);
    logic [34:0] r;
    case (n)
      1:       r = 35'd17179869184;
      2:       r = 35'd8589934592;
      3:       r = 35'd5726623062;
      4:       r = 35'd4294967296;
      5:       r = 35'd3435973837;
      6:       r = 35'd2863311531;
      7:       r = 35'd2454267027;
      8:       r = 35'd2147483648;
      9:       r = 35'd1908874354;
      10:      r = 35'd1717986919;
      11:      r = 35'd1561806290;
      12:      r = 35'd1431655766;
      13:      r = 35'd1321528399;
      default: r = 35'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/gal_arg.sv -----
// Front end: special cases, squares, floor test and the d^2/(2r^2) divider.
module gal_arg (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   en,
  input  logic                                   valid_i,
  input  logic                                   below_i,
  input  logic [gal_pkg::ANGLE_W-1:0]            theta_rec_i,
  input  logic [gal_pkg::ANGLE_W-1:0]            theta_exp_i,
  input  logic [gal_pkg::ANGLE_W-1:0]            theta_res_i,
  input  logic signed [gal_pkg::CFG_W-1:0]       min_exp_arg_i,
  output gal_pkg::side_t                         side_o,
  output logic [gal_pkg::QUOT_W-1:0]             quot_o,
  output logic                                   use_arg_o,
  output logic [gal_pkg::ANGLE_W-1:0]            res_o
);

  gal_pkg::side_t side0;
  logic [19:0]    diff;
  logic [10:0]    mag;

  gal_pkg::side_t s1_r, s2_r;
  logic [39:0]    d2_1_r, r2_1_r, d2_2_r, r2_2_r;
  logic [50:0]    mr2_r;
  logic [19:0]    res1_r, res2_r;

  gal_pkg::side_t ds_r   [gal_pkg::QUOT_W];
  logic [40:0]    rem_r  [gal_pkg::QUOT_W];
  logic [29:0]    xq_r   [gal_pkg::QUOT_W];
  logic [40:0]    y_r    [gal_pkg::QUOT_W];
  logic           ua_r   [gal_pkg::QUOT_W];
  logic [19:0]    dres_r [gal_pkg::QUOT_W];

  always_comb begin
    side0.vld  = valid_i;
    side0.zero = below_i | (theta_exp_i < gal_pkg::TINY_EXP);
    side0.sat  = (theta_res_i == '0);
  end

  assign diff = (theta_rec_i >= theta_exp_i) ? theta_rec_i - theta_exp_i
                                             : theta_exp_i - theta_rec_i;
  assign mag  = 11'(-min_exp_arg_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
      s2_r <= '0;
    end else if (en) begin
      s1_r <= side0;
      s2_r <= s1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d2_1_r <= {20'b0, diff} * {20'b0, diff};
      r2_1_r <= {20'b0, theta_res_i} * {20'b0, theta_res_i};
      res1_r <= theta_res_i;
      d2_2_r <= d2_1_r;
      r2_2_r <= r2_1_r;
      mr2_r  <= {40'b0, mag} * {11'b0, r2_1_r};
      res2_r <= res1_r;
    end
  end

  // restoring divide, one quotient bit per stage; the quotient fits 30 bits
  // whenever the argument lies above the floor
  for (genvar k = 0; k < gal_pkg::QUOT_W; k++) begin : g_div
    gal_pkg::side_t side_in;
    logic [40:0]    rem_in;
    logic [29:0]    xq_in;
    logic [40:0]    y_in;
    logic           ua_in;
    logic [19:0]    res_in;
    logic [41:0]    shr;
    logic           ge;

    if (k == 0) begin : g_head
      assign side_in = s2_r;
      assign rem_in  = {11'b0, d2_2_r[39:10]};
      assign xq_in   = {d2_2_r[9:0], 20'b0};
      assign y_in    = {r2_2_r, 1'b0};
      assign ua_in   = min_exp_arg_i[10] && ({12'b0, d2_2_r} < {mr2_r, 1'b0});
      assign res_in  = res2_r;
    end else begin : g_body
      assign side_in = ds_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign xq_in   = xq_r[k-1];
      assign y_in    = y_r[k-1];
      assign ua_in   = ua_r[k-1];
      assign res_in  = dres_r[k-1];
    end

    assign shr = {rem_in, xq_in[29]};
    assign ge  = (shr >= {1'b0, y_in});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ds_r[k] <= '0;
      end else if (en) begin
        ds_r[k] <= side_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? 41'(shr - {1'b0, y_in}) : shr[40:0];
        xq_r[k]   <= {xq_in[28:0], ge};
        y_r[k]    <= y_in;
        ua_r[k]   <= ua_in;
        dres_r[k] <= res_in;
      end
    end
  end

  assign side_o    = ds_r[gal_pkg::QUOT_W-1];
  assign quot_o    = xq_r[gal_pkg::QUOT_W-1];
  assign use_arg_o = ua_r[gal_pkg::QUOT_W-1];
  assign res_o     = dres_r[gal_pkg::QUOT_W-1];

endmodule

// ----- rtl/gal_exp2.sv -----
// Exponent to base two and the 2^f Taylor series, two stages per term.
module gal_exp2 (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  gal_pkg::side_t                   side_i,
  input  logic [gal_pkg::QUOT_W-1:0]       quot_i,
  input  logic                             use_arg_i,
  input  logic [gal_pkg::ANGLE_W-1:0]      res_i,
  input  logic signed [gal_pkg::CFG_W-1:0] min_exp_arg_i,
  output gal_pkg::side_t                   side_o,
  output logic [31:0]                      sum_o,
  output logic [11:0]                      kb_o,
  output logic [gal_pkg::ANGLE_W-1:0]      res_o
);

  localparam int N = gal_pkg::TAYLOR_N;

  logic signed [31:0] e;
  logic [63:0]        t;
  logic [59:0]        gprod;

  gal_pkg::side_t s1_r, s2_r;
  logic [63:0]    prod1_r;
  logic [19:0]    res1_r, res2_r;
  logic [29:0]    g2_r;
  logic [11:0]    kb2_r;

  gal_pkg::side_t sa_r     [N];
  logic [29:0]    p_a_r    [N];
  logic [31:0]    sum_a_r  [N];
  logic [29:0]    g_a_r    [N];
  logic [11:0]    kb_a_r   [N];
  logic [19:0]    res_a_r  [N];

  gal_pkg::side_t sb_r     [N];
  logic [30:0]    term_b_r [N];
  logic [31:0]    sum_b_r  [N];
  logic [29:0]    g_b_r    [N];
  logic [11:0]    kb_b_r   [N];
  logic [19:0]    res_b_r  [N];

  assign e = use_arg_i ? -$signed({2'b00, quot_i})
                       : 32'($signed({min_exp_arg_i, 20'b0}));

  // t = e*log2(e) in Q50 plus bias; integer part to kb, fraction to f
  assign t     = prod1_r + gal_pkg::EXP_BIAS;
  assign gprod = 60'({t[49:30], 10'b0}) * 60'(gal_pkg::LN2_Q30);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
      s2_r <= '0;
    end else if (en) begin
      s1_r <= side_i;
      s2_r <= s1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod1_r <= 64'(e) * 64'(gal_pkg::LOG2E_Q30);
      res1_r  <= res_i;
      g2_r    <= gprod[59:30];
      kb2_r   <= t[61:50];
      res2_r  <= res1_r;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_term
    gal_pkg::side_t side_in;
    logic [30:0]    term_in;
    logic [31:0]    sum_in;
    logic [29:0]    g_in;
    logic [11:0]    kb_in;
    logic [19:0]    res_in;
    logic [60:0]    tp;
    logic [64:0]    rp;

    if (k == 0) begin : g_head
      assign side_in = s2_r;
      assign term_in = gal_pkg::TERM_ONE;
      assign sum_in  = gal_pkg::SUM_ONE;
      assign g_in    = g2_r;
      assign kb_in   = kb2_r;
      assign res_in  = res2_r;
    end else begin : g_body
      assign side_in = sb_r[k-1];
      assign term_in = term_b_r[k-1];
      assign sum_in  = sum_b_r[k-1];
      assign g_in    = g_b_r[k-1];
      assign kb_in   = kb_b_r[k-1];
      assign res_in  = res_b_r[k-1];
    end

    assign tp = 61'(term_in) * 61'(g_in);
    // divide by the term index through its reciprocal
    assign rp = 65'(p_a_r[k]) * 65'(gal_pkg::recip(k + 1));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sa_r[k] <= '0;
        sb_r[k] <= '0;
      end else if (en) begin
        sa_r[k] <= side_in;
        sb_r[k] <= sa_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        p_a_r[k]    <= tp[59:30];
        sum_a_r[k]  <= sum_in;
        g_a_r[k]    <= g_in;
        kb_a_r[k]   <= kb_in;
        res_a_r[k]  <= res_in;
        term_b_r[k] <= rp[64:34];
        sum_b_r[k]  <= sum_a_r[k] + 32'(rp[64:34]);
        g_b_r[k]    <= g_a_r[k];
        kb_b_r[k]   <= kb_a_r[k];
        res_b_r[k]  <= res_a_r[k];
      end
    end
  end

  assign side_o = sb_r[N-1];
  assign sum_o  = sum_b_r[N-1];
  assign kb_o   = kb_b_r[N-1];
  assign res_o  = res_b_r[N-1];

endmodule

// ----- rtl/gal_scale.sv -----
// Normalisation, 2^k scaling, division by the resolution and result format.
module gal_scale (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  gal_pkg::side_t                    side_i,
  input  logic [31:0]                       sum_i,
  input  logic [11:0]                       kb_i,
  input  logic [gal_pkg::ANGLE_W-1:0]       res_i,
  output logic                              valid_o,
  output logic [gal_pkg::PROB_W-1:0]        probability_o,
  output logic                              saturated_o
);

  localparam int M = gal_pkg::PDIV_W;

  logic [11:0] nsh;

  gal_pkg::side_t s1_r, s2_r;
  logic [59:0]    num_r, numsh_r;
  logic           far_r;
  logic [5:0]     nsh_r;
  logic [19:0]    res1_r, res2_r;

  gal_pkg::side_t qs_r   [M];
  logic [19:0]    rem_r  [M];
  logic [31:0]    xq_r   [M];
  logic [19:0]    qres_r [M];

  logic                       out_vld_r;
  logic [gal_pkg::PROB_W-1:0] prob_r;
  logic                       sat_r;
  gal_pkg::side_t             last;

  assign nsh = gal_pkg::KB_UNITY - kb_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
      s2_r <= '0;
    end else if (en) begin
      s1_r <= side_i;
      // 2^k at or above one always overflows: mantissa/res exceeds 2^38
      s2_r <= '{vld: s1_r.vld, zero: s1_r.zero, sat: s1_r.sat | (nsh_r == '0 && !far_r)};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r   <= 60'(sum_i) * 60'(gal_pkg::INV_NORM_Q32);
      far_r   <= (kb_i < gal_pkg::KB_UNITY) && (nsh >= gal_pkg::KB_FAR);
      nsh_r   <= (kb_i < gal_pkg::KB_UNITY) ? nsh[5:0] : 6'd0;
      res1_r  <= res_i;
      numsh_r <= far_r ? '0 : num_r >> nsh_r;
      res2_r  <= res1_r;
    end
  end

  for (genvar k = 0; k < M; k++) begin : g_div
    gal_pkg::side_t side_in;
    logic [19:0]    rem_in;
    logic [31:0]    xq_in;
    logic [19:0]    res_in;
    logic [20:0]    shr;
    logic           ge;

    if (k == 0) begin : g_head
      logic ovf;
      // quotient reaches 2^32 exactly when the top bits are not below res
      assign ovf     = (numsh_r[59:32] >= {8'b0, res2_r});
      assign side_in = '{vld: s2_r.vld, zero: s2_r.zero, sat: s2_r.sat | ovf};
      assign rem_in  = numsh_r[51:32];
      assign xq_in   = numsh_r[31:0];
      assign res_in  = res2_r;
    end else begin : g_body
      assign side_in = qs_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign xq_in   = xq_r[k-1];
      assign res_in  = qres_r[k-1];
    end

    assign shr = {rem_in, xq_in[31]};
    assign ge  = (shr >= {1'b0, res_in});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        qs_r[k] <= '0;
      end else if (en) begin
        qs_r[k] <= side_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? 20'(shr - {1'b0, res_in}) : shr[19:0];
        xq_r[k]   <= {xq_in[30:0], ge};
        qres_r[k] <= res_in;
      end
    end
  end

  assign last = qs_r[M-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= last.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (last.zero) begin
        prob_r <= '0;
        sat_r  <= 1'b0;
      end else if (last.sat) begin
        prob_r <= gal_pkg::OUT_MAX;
        sat_r  <= 1'b1;
      end else begin
        prob_r <= xq_r[M-1];
        sat_r  <= 1'b0;
      end
    end
  end

  assign valid_o       = out_vld_r;
  assign probability_o = prob_r;
  assign saturated_o   = sat_r;

endmodule

// ----- rtl/gaussian_angle_likelihood.sv -----
// Gaussian angle likelihood: exp(-0.5*((rec-exp)/res)^2) / ((2*pi)^1.5 * res) in Q16.16.
// Fully pipelined: one item per cycle unless a waiting result is stalled. The pipeline depth
// comes mostly from two restoring dividers of one bit per stage (30 stages for the exponent
// argument, 32 for the division by the resolution) and the 13-term 2^f series at two
// stages a term. A stalled result freezes the whole pipeline, so in_stall follows out_stall
// while a result is waiting. The exponent floor min_exp_arg sits at byte address 0; the user
// must write it only while no item is in flight, which the block itself does not enforce.
module gaussian_angle_likelihood (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_below_threshold,
  input  logic [gal_pkg::ANGLE_W-1:0]   in_theta_rec,
  input  logic [gal_pkg::ANGLE_W-1:0]   in_theta_exp,
  input  logic [gal_pkg::ANGLE_W-1:0]   in_theta_res,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [gal_pkg::PROB_W-1:0]    out_probability,
  output logic                          out_saturated,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gal_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic                              en;
  logic signed [gal_pkg::CFG_W-1:0]  min_exp_arg_r;

  gal_pkg::side_t                    arg_side, exp_side;
  logic [gal_pkg::QUOT_W-1:0]        arg_quot;
  logic                              arg_use;
  logic [gal_pkg::ANGLE_W-1:0]       arg_res, exp_res;
  logic [31:0]                       exp_sum;
  logic [11:0]                       exp_kb;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_exp_arg_r <= gal_pkg::MIN_EXP_ARG_RST;
    end else if (psel && penable && pwrite && pready &&
                 paddr == gal_pkg::ADDR_MIN_EXP_ARG) begin
      min_exp_arg_r <= pwdata[gal_pkg::CFG_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == gal_pkg::ADDR_MIN_EXP_ARG) ? 32'(min_exp_arg_r) : '0;

  gal_arg u_arg (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .valid_i       (in_valid),
    .below_i       (in_below_threshold),
    .theta_rec_i   (in_theta_rec),
    .theta_exp_i   (in_theta_exp),
    .theta_res_i   (in_theta_res),
    .min_exp_arg_i (min_exp_arg_r),
    .side_o        (arg_side),
    .quot_o        (arg_quot),
    .use_arg_o     (arg_use),
    .res_o         (arg_res)
  );

  gal_exp2 u_exp2 (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .side_i        (arg_side),
    .quot_i        (arg_quot),
    .use_arg_i     (arg_use),
    .res_i         (arg_res),
    .min_exp_arg_i (min_exp_arg_r),
    .side_o        (exp_side),
    .sum_o         (exp_sum),
    .kb_o          (exp_kb),
    .res_o         (exp_res)
  );

  gal_scale u_scale (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .side_i        (exp_side),
    .sum_i         (exp_sum),
    .kb_i          (exp_kb),
    .res_i         (exp_res),
    .valid_o       (out_valid),
    .probability_o (out_probability),
    .saturated_o   (out_saturated)
  );

endmodule

// ----- rtl/gal_checker.sv -----
// Port-level checks for the Gaussian angle likelihood block, bound to the top level.
module gal_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [gal_pkg::PROB_W-1:0]  out_probability,
  input logic                        out_saturated
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_probability) && $stable(out_saturated))
    else $error("stalled result changed");

  a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |-> out_probability == gal_pkg::OUT_MAX)
    else $error("saturated result not at maximum");

  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind gaussian_angle_likelihood gal_checker u_gal_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_probability (out_probability),
  .out_saturated   (out_saturated)
);
